[rtl/oxygen_cell_cycle_rate_eval_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the oxygen cell-cycle rate evaluator
// ---------------------------------------------------------------------------
`ifndef OXYGEN_CELL_CYCLE_RATE_EVAL_TOP_MACROS_SVH
`define OXYGEN_CELL_CYCLE_RATE_EVAL_TOP_MACROS_SVH

// implication checked outside reset
`define OCRE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in and out of reset
`define OCRE_ASSERT_IMP_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/ocre_pkg.sv]
// ---------------------------------------------------------------------------
// ocre_pkg
// Shared widths, constants and helpers of the rate evaluator.
// ---------------------------------------------------------------------------
`default_nettype none
package ocre_pkg;

  localparam int unsigned FracBits   = 16;
  localparam int unsigned LvlW       = 24;
  localparam int unsigned QuotW      = FracBits + 1;
  localparam int unsigned DivSteps   = QuotW;
  localparam int unsigned RateW      = 32;
  localparam int unsigned SumW       = 37;
  localparam int unsigned InDataW    = 104;
  localparam int unsigned OutDataW   = 104;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [LvlW-1:0] P53Production = 24'd65536;
  localparam logic [LvlW-1:0] VegfSelfHalf  = 24'd65536;
  localparam logic [LvlW:0]   PhaseOne      = 25'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CYCLE_GAIN   = 3'd0,
    CFG_PHASE_HALF   = 3'd1,
    CFG_P53_DEG      = 3'd2,
    CFG_P53_HALF     = 3'd3,
    CFG_VEGF_PROD    = 3'd4,
    CFG_VEGF_P53     = 3'd5,
    CFG_VEGF_DEG     = 3'd6,
    CFG_VEGF_HALF    = 3'd7
  } cfg_idx_e;

  function automatic logic [RateW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'(33'sh7FFF_FFFF));
    lo = -SumW'(signed'(33'sh8000_0000));
    if (v > hi) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[RateW-1:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/oxygen_cell_cycle_rate_eval_top.sv]
// ---------------------------------------------------------------------------
// oxygen_cell_cycle_rate_eval_top
// One cell's ODE right-hand side: phase, p53 and VEGF rates plus stop flag.
// ---------------------------------------------------------------------------
// Pipeline: entry stage, 17 divider stages, multiply stage, sum/clamp stage.
// Throughput: one beat per cycle; the whole pipeline stalls only while the
//   output beat is held by the sink.
// Reset: rst_ni clears all valid bits and loads every configuration register with 1.0.
`default_nettype none
module oxygen_cell_cycle_rate_eval_top import ocre_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [LvlW-1:0]     cfg_data_i,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // phase_level[23:0], p53_level[47:24], vegf_level[71:48],
  // oxygen_level[95:72], cycling[96], zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // phase_rate[31:0], p53_rate[63:32], vegf_rate[95:64], stop_event[96], pad
  output logic [OutDataW-1:0]      m_axis_tdata_o
);

  localparam int unsigned Lat = DivSteps + 3;

  // configuration registers
  logic [LvlW-1:0] cycle_gain_q, phase_half_q, p53_deg_q, p53_half_q;
  logic [LvlW-1:0] vegf_prod_q, vegf_p53_q, vegf_deg_q, vegf_half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cycle_gain_q <= 24'd65536;
      phase_half_q <= 24'd65536;
      p53_deg_q    <= 24'd65536;
      p53_half_q   <= 24'd65536;
      vegf_prod_q  <= 24'd65536;
      vegf_p53_q   <= 24'd65536;
      vegf_deg_q   <= 24'd65536;
      vegf_half_q  <= 24'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CYCLE_GAIN: cycle_gain_q <= cfg_data_i;
        CFG_PHASE_HALF: phase_half_q <= cfg_data_i;
        CFG_P53_DEG:    p53_deg_q    <= cfg_data_i;
        CFG_P53_HALF:   p53_half_q   <= cfg_data_i;
        CFG_VEGF_PROD:  vegf_prod_q  <= cfg_data_i;
        CFG_VEGF_P53:   vegf_p53_q   <= cfg_data_i;
        CFG_VEGF_DEG:   vegf_deg_q   <= cfg_data_i;
        CFG_VEGF_HALF:  vegf_half_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input fields
  logic [LvlW-1:0] phase_lvl, p53_lvl, vegf_lvl, oxy_lvl;
  logic            cycling;
  assign phase_lvl = s_axis_tdata_i[23:0];
  assign p53_lvl   = s_axis_tdata_i[47:24];
  assign vegf_lvl  = s_axis_tdata_i[71:48];
  assign oxy_lvl   = s_axis_tdata_i[95:72];
  assign cycling   = s_axis_tdata_i[96];

  // global stall: everything moves when the output slot is free or taken
  logic en;
  logic vld_q [0:Lat-1];
  assign en              = !vld_q[Lat-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // entry stage: level products, side flags
  logic [47:0] p53_loss_full, vegf_gain_full, vegf_loss_full;
  assign p53_loss_full  = p53_deg_q  * p53_lvl;
  assign vegf_gain_full = vegf_p53_q * p53_lvl;
  assign vegf_loss_full = vegf_deg_q * vegf_lvl;

  logic [RateW-1:0] p53m_q [0:DivSteps];
  logic [RateW-1:0] vgm_q  [0:DivSteps];
  logic [RateW-1:0] vlm_q  [0:DivSteps];
  logic             cyc_q  [0:DivSteps];
  logic             stop_q [0:DivSteps];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p53m_q[0] <= p53_loss_full[47:16];
      vgm_q[0]  <= vegf_gain_full[47:16];
      vlm_q[0]  <= vegf_loss_full[47:16];
      cyc_q[0]  <= cycling;
      stop_q[0] <= ({1'b0, phase_lvl} > PhaseOne);
      for (int i = 1; i <= DivSteps; i++) begin
        p53m_q[i] <= p53m_q[i-1];
        vgm_q[i]  <= vgm_q[i-1];
        vlm_q[i]  <= vlm_q[i-1];
        cyc_q[i]  <= cyc_q[i-1];
        stop_q[i] <= stop_q[i-1];
      end
    end
  end

  // saturating oxygen / VEGF fractions
  logic [QuotW-1:0] sat_phase, sat_p53, sat_vself, sat_vdeg;

  ocre_div u_div_phase (.clk_i, .en_i(en), .x_i(oxy_lvl),
                        .half_i(phase_half_q), .quot_o(sat_phase));
  ocre_div u_div_p53   (.clk_i, .en_i(en), .x_i(oxy_lvl),
                        .half_i(p53_half_q), .quot_o(sat_p53));
  ocre_div u_div_vself (.clk_i, .en_i(en), .x_i(vegf_lvl),
                        .half_i(VegfSelfHalf), .quot_o(sat_vself));
  ocre_div u_div_vdeg  (.clk_i, .en_i(en), .x_i(oxy_lvl),
                        .half_i(vegf_half_q), .quot_o(sat_vdeg));

  // multiply stage
  logic [40:0] phase_full;
  logic [48:0] p53l_full, vg_full, vl_full;
  assign phase_full = cycle_gain_q * sat_phase;
  assign p53l_full  = p53m_q[DivSteps] * sat_p53;
  assign vg_full    = vgm_q[DivSteps] * sat_vself;
  assign vl_full    = vlm_q[DivSteps] * sat_vdeg;

  logic [24:0] phase_m_q;
  logic [32:0] p53l_m_q, vg_m_q, vl_m_q;
  logic        stop_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      phase_m_q <= cyc_q[DivSteps] ? phase_full[40:16] : '0;
      p53l_m_q  <= p53l_full[48:16];
      vg_m_q    <= vg_full[48:16];
      vl_m_q    <= vl_full[48:16];
      stop_m_q  <= stop_q[DivSteps];
    end
  end

  // sum and clamp stage
  logic signed [SumW-1:0] p53_sum, vegf_sum;
  assign p53_sum  = signed'({13'd0, P53Production}) - signed'({4'd0, p53l_m_q});
  assign vegf_sum = signed'({13'd0, vegf_prod_q}) + signed'({4'd0, vg_m_q})
                  - signed'({4'd0, vl_m_q});

  logic [RateW-1:0] phase_r_q, p53_r_q, vegf_r_q;
  logic             stop_r_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      phase_r_q <= {7'd0, phase_m_q};
      p53_r_q   <= sat32(p53_sum);
      vegf_r_q  <= sat32(vegf_sum);
      stop_r_q  <= stop_m_q;
    end
  end

  assign m_axis_tvalid_o = vld_q[Lat-1];
  assign m_axis_tdata_o  = {7'd0, stop_r_q, vegf_r_q, p53_r_q, phase_r_q};

endmodule
`default_nettype wire

[rtl/ocre_div.sv]
// ---------------------------------------------------------------------------
// ocre_div
// Pipelined restoring divider for x*2^F / (x + half), one quotient bit/stage.
// ---------------------------------------------------------------------------
`default_nettype none
module ocre_div import ocre_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [LvlW-1:0]  x_i,
  input  wire logic [LvlW-1:0]  half_i,
  output logic      [QuotW-1:0] quot_o
);

  // entry stage plus one stage per quotient bit
  logic [LvlW:0]    rem_q  [0:DivSteps];
  logic [LvlW:0]    den_q  [0:DivSteps];
  logic [QuotW-1:0] quo_q  [0:DivSteps];
  logic             lsb_q  [0:DivSteps];
  logic             zero_q [0:DivSteps];

  logic [LvlW:0] den_d;
  assign den_d = {1'b0, x_i} + {1'b0, half_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {2'b00, x_i[LvlW-1:1]};
      den_q[0]  <= den_d;
      quo_q[0]  <= '0;
      lsb_q[0]  <= x_i[0];
      zero_q[0] <= (den_d == '0);
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [LvlW+1:0] shl;
    logic [LvlW+2:0] diff;
    logic            bit_in;
    assign bit_in = (k == 0) ? lsb_q[k] : 1'b0;
    assign shl    = {rem_q[k], bit_in};
    assign diff   = {1'b0, shl} - {2'b00, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= diff[LvlW+2] ? shl[LvlW:0] : diff[LvlW:0];
        den_q[k+1]  <= den_q[k];
        quo_q[k+1]  <= {quo_q[k][QuotW-2:0], ~diff[LvlW+2]};
        lsb_q[k+1]  <= lsb_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  assign quot_o = zero_q[DivSteps] ? '0 : quo_q[DivSteps];

endmodule
`default_nettype wire

[rtl/ocre_checker.sv]
// ---------------------------------------------------------------------------
// ocre_checker
// Port-level checks of the rate evaluator, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "oxygen_cell_cycle_rate_eval_top_macros.svh"
module ocre_checker import ocre_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o
);

  `OCRE_ASSERT_IMP_ALL(a_rst_no_beat, !rst_ni, !m_axis_tvalid_o, "beat during reset")
  `OCRE_ASSERT_IMP(a_hold, m_axis_tvalid_o && !m_axis_tready_i, ##1 $stable(m_axis_tdata_o), "stalled beat changed")
  `OCRE_ASSERT_IMP(a_ready_free, !m_axis_tvalid_o, s_axis_tready_o, "not ready with empty output")
  `OCRE_ASSERT_IMP(a_phase_pos, m_axis_tvalid_o, !m_axis_tdata_o[31], "negative phase rate")

endmodule

bind oxygen_cell_cycle_rate_eval_top ocre_checker u_ocre_checker (
  .clk_i, .rst_ni, .s_axis_tready_o, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
);
`default_nettype wire

[tb/oxygen_cell_cycle_rate_eval_top_tb.sv]
// ---------------------------------------------------------------------------
// oxygen_cell_cycle_rate_eval_top_tb
// Streams cell states through the rate evaluator and checks every output
// beat against a cycle-free predictor of the phase, p53 and VEGF rates.
// ---------------------------------------------------------------------------
`default_nettype none
module oxygen_cell_cycle_rate_eval_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ocre_pkg::*;

  localparam int unsigned IdleLimit = 3000;  // cycles without any beat
  localparam int unsigned Drain     = 30;    // pipeline is 20 deep
  localparam int unsigned LongHold  = 400;
  localparam logic [LvlW-1:0] LvlMax = 24'hFF_FFFF;
  localparam logic [LvlW-1:0] LvlOne = 24'd65536;

  typedef struct packed {
    logic [LvlW-1:0] phase;
    logic [LvlW-1:0] p53;
    logic [LvlW-1:0] vegf;
    logic [LvlW-1:0] oxy;
    logic            cycling;
  } cell_t;

  typedef struct packed {
    logic [RateW-1:0] phase_rate;
    logic [RateW-1:0] p53_rate;
    logic [RateW-1:0] vegf_rate;
    logic             stop_event;
  } rates_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [LvlW-1:0]      cfg_data_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [InDataW-1:0]   s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [OutDataW-1:0]  m_axis_tdata_o;

  oxygen_cell_cycle_rate_eval_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  // predictor's copy of the register file
  logic [LvlW-1:0] coef [8];
  rates_t          rates_q [$];
  int unsigned     errors, beats_in, beats_out, idle_cycles;
  bit              idle_en;   // random idling on both sides
  bit              hold_go, hold_done;

  // ---- predictor ---------------------------------------------------------
  function automatic longint unsigned sat_frac(longint unsigned x, longint unsigned h);
    if (x + h == 0) return 0;   // half level and variable both zero
    return (x << FracBits) / (x + h);
  endfunction

  function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
    return (a * b) >> FracBits;
  endfunction

  function automatic logic [RateW-1:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[RateW-1:0];
  endfunction

  function automatic rates_t cell_rates(cell_t c);
    rates_t r;
    longint ph, p5, vg;
    ph = c.cycling ? longint'(fmul(coef[CFG_CYCLE_GAIN], sat_frac(c.oxy, coef[CFG_PHASE_HALF])))
                   : 0;
    p5 = longint'(P53Production)
         - longint'(fmul(fmul(coef[CFG_P53_DEG], c.p53), sat_frac(c.oxy, coef[CFG_P53_HALF])));
    vg = longint'(coef[CFG_VEGF_PROD])
         + longint'(fmul(fmul(coef[CFG_VEGF_P53], c.p53), sat_frac(c.vegf, VegfSelfHalf)))
         - longint'(fmul(fmul(coef[CFG_VEGF_DEG], c.vegf), sat_frac(c.oxy, coef[CFG_VEGF_HALF])));
    r.phase_rate = clamp(ph);
    r.p53_rate   = clamp(p5);
    r.vegf_rate  = clamp(vg);
    r.stop_event = ({1'b0, c.phase} > PhaseOne);
    return r;
  endfunction

  // ---- sink side: ready bursts, long hold -------------------------------
  int unsigned stall_left, hold_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_left = 0; hold_cnt = 0; hold_done = 0;
    end else if (hold_go && !hold_done) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= LongHold) hold_done = 1;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left = $urandom_range(1, 9) - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // ---- result checker and watchdog, sampled mid-cycle --------------------
  always @(negedge clk_i) begin
    rates_t got, exp_r;
    bit moved;
    moved = 0;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) moved = 1;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      moved = 1;
      beats_out++;
      got.phase_rate = m_axis_tdata_o[31:0];
      got.p53_rate   = m_axis_tdata_o[63:32];
      got.vegf_rate  = m_axis_tdata_o[95:64];
      got.stop_event = m_axis_tdata_o[96];
      if (rates_q.size() == 0) begin
        $error("output beat with no cell pending: %h", m_axis_tdata_o);
        errors++;
      end else begin
        exp_r = rates_q.pop_front();
        if (got.phase_rate !== exp_r.phase_rate) begin
          $error("phase_rate exp %h got %h", exp_r.phase_rate, got.phase_rate); errors++;
        end
        if (got.p53_rate !== exp_r.p53_rate) begin
          $error("p53_rate exp %h got %h", exp_r.p53_rate, got.p53_rate); errors++;
        end
        if (got.vegf_rate !== exp_r.vegf_rate) begin
          $error("vegf_rate exp %h got %h", exp_r.vegf_rate, got.vegf_rate); errors++;
        end
        if (got.stop_event !== exp_r.stop_event) begin
          $error("stop_event exp %b got %b", exp_r.stop_event, got.stop_event); errors++;
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no beat for %0d cycles", IdleLimit);
      $display("oxygen_cell_cycle_rate_eval_top test failed");
      $finish;
    end
  end

  // ---- source side -------------------------------------------------------
  // Offer one cell; returns at the edge where it is taken.
  task automatic send_cell(cell_t c);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'b0, c.cycling, c.oxy, c.vegf, c.p53, c.phase};
    @(negedge clk_i);
    while (!s_axis_tready_o) @(negedge clk_i);
    rates_q.insert(rates_q.size(), cell_rates(c));
    beats_in++;
    @(posedge clk_i);
  endtask

  task automatic stop_sending();
    s_axis_tvalid_i <= 1'b0;
    wait (rates_q.size() == 0);
    repeat (Drain) @(posedge clk_i);
  endtask

  // registers change only with the pipeline empty
  task automatic write_coef(cfg_idx_e idx, logic [LvlW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    coef[idx]  = val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic write_all(logic [LvlW-1:0] val);
    for (int i = 0; i < 8; i++) write_coef(cfg_idx_e'(i), val);
  endtask

  function automatic logic [LvlW-1:0] pick_level();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return LvlMax;
      2:       return LvlW'(LvlOne + $urandom_range(0, 2) - 1);
      3:       return LvlW'($urandom_range(0, 24'h3_FFFF));
      default: return LvlW'($urandom_range(0, 24'hFF_FFFF));
    endcase
  endfunction

  function automatic cell_t pick_cell();
    cell_t c;
    c.phase = pick_level(); c.p53 = pick_level();
    c.vegf  = pick_level(); c.oxy = pick_level();
    c.cycling = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // ---- tests -------------------------------------------------------------
  // Reset coefficients: extremes and the stop threshold.
  task automatic test_directed_defaults();
    send_cell('{'0, '0, '0, '0, 1'b0});
    send_cell('{'0, '0, '0, '0, 1'b1});
    send_cell('{LvlMax, LvlMax, LvlMax, LvlMax, 1'b1});
    send_cell('{LvlMax, LvlMax, LvlMax, LvlMax, 1'b0});
    send_cell('{LvlOne, LvlOne, LvlOne, LvlOne, 1'b1});      // phase exactly 1.0
    send_cell('{LvlOne + 24'd1, 24'd1, 24'd1, 24'd1, 1'b1}); // just past 1.0
    send_cell('{LvlOne - 24'd1, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1});
    send_cell('{24'h555555, 24'h555555, 24'hAAAAAA, 24'h555555, 1'b0});
    stop_sending();
  endtask

  // Zero half levels with zero oxygen give zero fractions; max coefs saturate.
  task automatic test_directed_coef_extremes();
    write_all('0);
    send_cell('{LvlMax, LvlMax, LvlMax, '0, 1'b1});
    send_cell('{'0, LvlMax, '0, LvlMax, 1'b1});
    send_cell('{LvlOne, 24'd7, 24'd9, '0, 1'b0});
    stop_sending();
    write_all(LvlMax);
    write_coef(CFG_PHASE_HALF, '0);
    write_coef(CFG_P53_HALF, '0);
    write_coef(CFG_VEGF_HALF, '0);
    send_cell('{'0, LvlMax, LvlMax, '0, 1'b1});
    send_cell('{LvlMax, LvlMax, LvlMax, LvlMax, 1'b1});
    send_cell('{LvlMax, LvlMax, '0, LvlMax, 1'b1});          // p53 rate floor
    send_cell('{LvlMax, LvlMax, LvlMax, 24'd1, 1'b1});       // vegf gain and loss nearly cancel
    send_cell('{LvlMax, '0, '0, LvlMax, 1'b0});
    stop_sending();
    write_all(LvlMax);
    send_cell('{LvlMax, LvlMax, LvlMax, LvlMax, 1'b1});
    send_cell('{'0, '0, LvlMax, LvlMax, 1'b1});
    stop_sending();
  endtask

  // Random cells under a series of random coefficient sets.
  task automatic test_random_sets(int unsigned sets, int unsigned per_set);
    for (int s = 0; s < sets; s++) begin
      for (int i = 0; i < 8; i++) write_coef(cfg_idx_e'(i), pick_level());
      repeat (per_set) send_cell(pick_cell());
      stop_sending();
    end
  endtask

  // Sink holds off a long time; the pipeline fills and stalls its input.
  task automatic test_backpressure();
    hold_go = 1;
    repeat (80) send_cell(pick_cell());
    wait (hold_done);
    hold_go = 0;
    stop_sending();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0; cfg_idx_i <= CFG_CYCLE_GAIN; cfg_data_i <= '0;
    s_axis_tvalid_i <= 1'b0; s_axis_tdata_i <= '0;
    errors = 0; beats_in = 0; beats_out = 0; idle_cycles = 0;
    idle_en = 0; hold_go = 0;
    for (int i = 0; i < 8; i++) coef[i] = LvlOne;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_defaults();
    idle_en = 1;
    test_directed_coef_extremes();
    test_random_sets(14, 120);
    test_backpressure();
    idle_en = 0;                 // closing stretch runs back to back
    test_random_sets(1, 150);

    $display("cells sent %0d, rate beats checked %0d, over 19 coefficient sets",
             beats_in, beats_out);
    if (errors == 0) begin
      $display("oxygen_cell_cycle_rate_eval_top test passed");
    end else begin
      $display("oxygen_cell_cycle_rate_eval_top test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
